### hw/rtl/lhe_pkg.sv
// ----------------------------------------------------------------------------
// Luma histogram engine package
// Shared constants, request codes and the command type passed from the front
// end to the back end through the command queue.
// ----------------------------------------------------------------------------
package lhe_pkg;

    localparam int MAX_WIDTH_DEF      = 4096;
    localparam int BIN_COUNT_BITS_DEF = 24;

    localparam int DIM_W       = 13;
    localparam int COUNT_OUT_W = 24;
    localparam int NUM_BINS    = 256;
    localparam int BIN_W       = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_W = 1;

    localparam logic [15:0] COEF_R = 16'd13933;
    localparam logic [15:0] COEF_G = 16'd46871;
    localparam logic [15:0] COEF_B = 16'd4732;

    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [1:0] PHASE_BLUE  = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_RED   = 2'd2;

    typedef enum logic [1:0] {
        OP_BUMP,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [BIN_W-1:0] bin;
    } lhe_cmd_t;

endpackage

### hw/rtl/lhe_front.sv
// ----------------------------------------------------------------------------
// Luma histogram engine front end
// Accepts items, tracks the position in the padded pixel array and turns
// complete pixels, bin reads and clears into commands for the back end.
// ----------------------------------------------------------------------------
module lhe_front
    import lhe_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       req_type,
    input  logic [7:0]       pixel_byte,
    input  logic [BIN_W-1:0] bin_index,
    input  logic [DIM_W-1:0] image_width,
    input  logic [DIM_W-1:0] image_height,
    input  logic             q_full,
    output logic             q_push,
    output lhe_cmd_t         q_cmd
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = (WW > DIM_W) ? WW : DIM_W;
    localparam int LEN_W = $clog2(3 * MAX_WIDTH + 4);

    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [7:0]       blue_reg, blue_next;
    logic [7:0]       green_reg, green_next;
    logic [1:0]       phase_reg, phase_next;

    logic [CW-1:0]    w_ext;
    logic [CW-1:0]    eff_w;
    logic [LEN_W-1:0] data_len;
    logic [LEN_W-1:0] pad_len;
    logic [LEN_W-1:0] row_len;
    logic [LEN_W:0]   pos_inc;
    logic             row_end;
    logic             accept;

    assign w_ext    = CW'(image_width);
    assign eff_w    = (w_ext == '0) ? CW'(1) :
                      ((w_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_ext);
    assign data_len = LEN_W'({eff_w, 1'b0}) + LEN_W'(eff_w);
    assign pad_len  = data_len + LEN_W'(3);
    assign row_len  = {pad_len[LEN_W-1:2], 2'b00};
    assign pos_inc  = {1'b0, pos_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign row_end  = pos_inc >= {1'b0, row_len};
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        pos_next        = pos_reg;
        row_next        = row_reg;
        blue_next       = blue_reg;
        green_next      = green_reg;
        phase_next      = phase_reg;
        q_push          = 1'b0;
        q_cmd.op        = OP_READ;
        q_cmd.red       = pixel_byte;
        q_cmd.green     = green_reg;
        q_cmd.blue      = blue_reg;
        q_cmd.bin       = bin_index;
        if (accept)
        begin
            unique case (req_type)
                REQ_PIXEL:
                begin
                    if (row_reg < image_height)
                    begin
                        if (pos_reg < data_len)
                        begin
                            unique case (phase_reg)
                                PHASE_BLUE:
                                begin
                                    blue_next  = pixel_byte;
                                    phase_next = PHASE_GREEN;
                                end
                                PHASE_GREEN:
                                begin
                                    green_next = pixel_byte;
                                    phase_next = PHASE_RED;
                                end
                                default:
                                begin
                                    q_push     = 1'b1;
                                    q_cmd.op   = OP_BUMP;
                                    phase_next = PHASE_BLUE;
                                end
                            endcase
                        end
                        if (row_end)
                        begin
                            pos_next   = '0;
                            phase_next = PHASE_BLUE;
                            row_next   = row_reg + 1'b1;
                        end
                        else
                        begin
                            pos_next = pos_inc[LEN_W-1:0];
                        end
                    end
                end
                REQ_READ:
                begin
                    q_push   = 1'b1;
                    q_cmd.op = OP_READ;
                end
                REQ_CLEAR:
                begin
                    q_push     = 1'b1;
                    q_cmd.op   = OP_CLEAR;
                    pos_next   = '0;
                    row_next   = '0;
                    blue_next  = '0;
                    green_next = '0;
                    phase_next = PHASE_BLUE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            row_reg   <= '0;
            blue_reg  <= '0;
            green_reg <= '0;
            phase_reg <= PHASE_BLUE;
        end
        else
        begin
            pos_reg   <= pos_next;
            row_reg   <= row_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
            phase_reg <= phase_next;
        end
    end

endmodule

### hw/rtl/lhe_queue.sv
// ----------------------------------------------------------------------------
// Luma histogram engine command queue
// A short FIFO of commands that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lhe_queue
    import lhe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lhe_cmd_t push_cmd,
    input  logic     pop,
    output logic     full,
    output logic     head_valid,
    output lhe_cmd_t head_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lhe_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Command queue count exceeds its depth.");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Command queue lost a pushed item.");

endmodule

### hw/rtl/lhe_back.sv
// ----------------------------------------------------------------------------
// Luma histogram engine back end
// Computes the luma of each pixel, updates the saturating bin store with a
// forwarded read-modify-write, serves bin reads and clears the store.
// ----------------------------------------------------------------------------
module lhe_back
    import lhe_pkg::*;
#(
    parameter int BIN_COUNT_BITS = BIN_COUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  lhe_cmd_t               q_cmd,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COUNT_OUT_W-1:0] bin_count,
    output logic [BIN_W-1:0]       bin_number
);

    logic [BIN_COUNT_BITS-1:0] hist_mem [NUM_BINS];
    logic [NUM_BINS-1:0]       bin_vld_reg;

    logic                      advance;

    logic                      s1_vld_reg;
    op_t                       s1_op_reg;
    logic [BIN_W-1:0]          s1_bin_reg;
    logic [23:0]               pr_reg, pg_reg, pb_reg;

    logic                      s2_vld_reg;
    op_t                       s2_op_reg;
    logic [BIN_W-1:0]          s2_addr_reg;

    logic                      s3_vld_reg;
    op_t                       s3_op_reg;
    logic [BIN_W-1:0]          s3_addr_reg;
    logic [BIN_COUNT_BITS-1:0] mem_rd_reg;
    logic                      vld_rd_reg;

    logic                      last_wr_vld_reg;
    logic [BIN_W-1:0]          last_wr_addr_reg;
    logic [BIN_COUNT_BITS-1:0] last_wr_data_reg;
    logic                      clr_last_reg;

    logic                      out_valid_reg;
    logic [COUNT_OUT_W-1:0]    bin_count_reg;
    logic [BIN_W-1:0]          bin_number_reg;

    logic [23:0]               luma_sum;
    logic [BIN_W-1:0]          s2_addr_next;
    logic [BIN_COUNT_BITS-1:0] bin_old;
    logic [BIN_COUNT_BITS-1:0] bin_new;
    logic                      s3_bump;
    logic                      s3_read;
    logic                      s3_clear;

    assign advance = !out_valid_reg || !out_stall;
    assign q_pop   = advance && q_valid;

    assign luma_sum     = pr_reg + pg_reg + pb_reg;
    assign s2_addr_next = (s1_op_reg == OP_BUMP) ? luma_sum[23:16] : s1_bin_reg;

    always_comb
    begin
        if (last_wr_vld_reg && (last_wr_addr_reg == s3_addr_reg))
        begin
            bin_old = last_wr_data_reg;
        end
        else if (clr_last_reg || !vld_rd_reg)
        begin
            bin_old = '0;
        end
        else
        begin
            bin_old = mem_rd_reg;
        end
    end

    assign bin_new  = (&bin_old) ? bin_old : bin_old + 1'b1;
    assign s3_bump  = advance && s3_vld_reg && (s3_op_reg == OP_BUMP);
    assign s3_read  = advance && s3_vld_reg && (s3_op_reg == OP_READ);
    assign s3_clear = advance && s3_vld_reg && (s3_op_reg == OP_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg      <= 1'b0;
            s2_vld_reg      <= 1'b0;
            s3_vld_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_wr_vld_reg <= 1'b0;
            clr_last_reg    <= 1'b0;
            bin_vld_reg     <= '0;
        end
        else if (advance)
        begin
            s1_vld_reg      <= q_valid;
            s2_vld_reg      <= s1_vld_reg;
            s3_vld_reg      <= s2_vld_reg;
            out_valid_reg   <= s3_read;
            last_wr_vld_reg <= s3_bump;
            clr_last_reg    <= s3_clear;
            if (s3_clear)
            begin
                bin_vld_reg <= '0;
            end
            else if (s3_bump)
            begin
                bin_vld_reg[s3_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg        <= q_cmd.op;
            s1_bin_reg       <= q_cmd.bin;
            pr_reg           <= 24'(COEF_R) * 24'(q_cmd.red);
            pg_reg           <= 24'(COEF_G) * 24'(q_cmd.green);
            pb_reg           <= 24'(COEF_B) * 24'(q_cmd.blue);
            s2_op_reg        <= s1_op_reg;
            s2_addr_reg      <= s2_addr_next;
            s3_op_reg        <= s2_op_reg;
            s3_addr_reg      <= s2_addr_reg;
            mem_rd_reg       <= hist_mem[s2_addr_reg];
            vld_rd_reg       <= bin_vld_reg[s2_addr_reg];
            last_wr_addr_reg <= s3_addr_reg;
            last_wr_data_reg <= bin_new;
            if (s3_read)
            begin
                bin_count_reg  <= COUNT_OUT_W'(bin_old);
                bin_number_reg <= s3_addr_reg;
            end
            if (s3_bump)
            begin
                hist_mem[s3_addr_reg] <= bin_new;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin_count  = bin_count_reg;
    assign bin_number = bin_number_reg;

    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s3_read |=> out_valid_reg)
        else $error("A bin read did not produce a result item.");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        s3_clear |=> bin_vld_reg == '0)
        else $error("Clear left bins marked as written.");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(s3_vld_reg) && $stable(bin_vld_reg))
        else $error("Back end moved while the output was stalled.");

endmodule

### hw/rtl/luma_histogram_engine.sv
// ----------------------------------------------------------------------------
// Luma histogram engine
// Streams the bytes of a 24-bit bottom-up bitmap pixel array and builds a
// 256-bin BT.709 brightness histogram with saturating counts.
// ----------------------------------------------------------------------------
// The engine takes one item per cycle. A pixel byte or a request enters the
// front end, which skips row padding and rows past the configured height and
// queues one command per complete pixel, bin read or clear in a four-entry
// queue; items stall only while that queue is full. The back end runs four
// stages (coefficient products, luma sum, bin store read, update) and does
// one command per cycle while the output is not stalled, forwarding each
// bin update to the next command. The bin store is a 256-entry memory with
// one read and one write port; a clear works through per-bin written flags,
// with no sweep over the memory. Width and height are written through the
// configuration port and take effect at once; the user must write them only
// while the engine is idle, which the block itself does not enforce.
module luma_histogram_engine
    import lhe_pkg::*;
#(
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int BIN_COUNT_BITS = BIN_COUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             req_type,
    input  logic [7:0]             pixel_byte,
    input  logic [BIN_W-1:0]       bin_index,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COUNT_OUT_W-1:0] bin_count,
    output logic [BIN_W-1:0]       bin_number,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data
);

    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;

    logic             q_full;
    logic             q_push;
    lhe_cmd_t         q_push_cmd;
    logic             q_pop;
    logic             q_valid;
    lhe_cmd_t         q_head_cmd;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_W'(1);
            image_height_reg <= DIM_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    lhe_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .req_type     (req_type),
        .pixel_byte   (pixel_byte),
        .bin_index    (bin_index),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_push_cmd)
    );

    lhe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    lhe_back #(
        .BIN_COUNT_BITS (BIN_COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_head_cmd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_count  (bin_count),
        .bin_number (bin_number)
    );

endmodule
